### hdl/ecws_pkg.sv
// shared types and constants for the edge-clipped window smoother
package ecws_pkg;

  localparam int MAX_WINDOW  = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 14;
  localparam int HIST_DEPTH  = 32;
  localparam int PTR_W       = 5;
  localparam int SEEN_W      = 6;
  localparam int WLEN_W      = 5;
  localparam int HALF_W      = 4;
  localparam int PEND_W      = 5;
  localparam int SPAN_W      = 5;
  localparam int CIDX_W      = 5;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + 5;
  localparam int DVD_W       = ACC_W - COEF_FRAC;
  localparam int DCNT_W      = 5;
  localparam int MAX_BURST   = 16;

  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_PUSH      = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_EMIT
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_coef;
    logic push;
    logic setup;
    logic issue;
    logic div_start;
    logic div_step;
    logic emit;
    logic clear_seq;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_ok;
    logic last;
    logic k_done;
    logic mac_busy;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

### hdl/ecws_datapath.sv
// datapath: tables, sequence counters, mac pipeline, divider, output word
module ecws_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ecws_pkg::ctl_cmd_t                     cmd_i,
  output ecws_pkg::dp_status_t                   sts_o,
  input  logic                                   cfg_we_i,
  input  logic [ecws_pkg::WLEN_W-1:0]            cfg_wdata_i,
  input  logic [ecws_pkg::CIDX_W-1:0]            coef_index_i,
  input  logic signed [ecws_pkg::COEF_BITS-1:0]  coef_value_i,
  input  logic signed [ecws_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_sample_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [ecws_pkg::SAMPLE_BITS-1:0] smoothed_o,
  output logic                                   saturated_o,
  output logic                                   end_of_sequence_o
);
  import ecws_pkg::*;

  localparam logic [HALF_W-1:0] HMAX = HALF_W'((MAX_WINDOW - 1) / 2);
  localparam logic [DVD_W-1:0] POS_MAX = DVD_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [DVD_W-1:0] NEG_MAX = DVD_W'(1 << (SAMPLE_BITS - 1));

  logic [WLEN_W-1:0]             wlen_q;
  logic signed [COEF_BITS-1:0]   coef_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] hist_q [HIST_DEPTH];
  logic [PTR_W-1:0]              wptr_q;
  logic [SEEN_W-1:0]             seen_q;
  logic [PEND_W-1:0]             pend_q;
  logic [PEND_W-1:0]             burst_q;
  logic                          last_q;
  logic [SPAN_W-1:0]             span_q;
  logic [SPAN_W-1:0]             k_q;
  logic [PTR_W-1:0]              dist_q;
  logic signed [SAMPLE_BITS-1:0] rd_s_q;
  logic signed [COEF_BITS-1:0]   rd_c_q;
  logic                          v1_q, v2_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic                          neg_q;
  logic [DVD_W-1:0]              dq_q;
  logic [SPAN_W-1:0]             rem_q;
  logic [DCNT_W-1:0]             dcnt_q;
  logic                          out_valid_q;

  logic [HALF_W-1:0]  h_raw, h;
  logic [PEND_W-1:0]  back;
  logic [SEEN_W-1:0]  prior;
  logic [HALF_W-1:0]  left, right;
  logic [ACC_W-1:0]   acc_mag;
  logic [SPAN_W:0]    trial;
  logic               ge;
  logic [PTR_W-1:0]   rd_idx;

  // half span from window length
  always_comb begin
    h_raw = (wlen_q >= WLEN_W'(1)) ? HALF_W'((wlen_q - WLEN_W'(1)) >> 1) : '0;
    h     = (h_raw > HMAX) ? HMAX : h_raw;
  end

  // clipped window geometry for the oldest pending output
  always_comb begin
    back   = pend_q - PEND_W'(1);
    prior  = seen_q - SEEN_W'(pend_q);
    left   = (prior < SEEN_W'(h)) ? HALF_W'(prior) : h;
    right  = (back < PEND_W'(h)) ? HALF_W'(back) : h;
    rd_idx = wptr_q - PTR_W'(1) - dist_q;
  end

  // divider step and magnitude
  always_comb begin
    acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    trial   = {rem_q, dq_q[DVD_W-1]};
    ge      = (trial >= {1'b0, span_q});
  end

  // status
  always_comb begin
    sts_o.last     = last_q;
    sts_o.emit_ok  = last_q ? (pend_q != '0)
                            : ((pend_q > PEND_W'(h)) && (burst_q < PEND_W'(MAX_BURST)));
    sts_o.k_done   = (k_q == span_q);
    sts_o.mac_busy = v1_q | v2_q;
    sts_o.div_done = (dcnt_q == '0);
    sts_o.out_full = out_valid_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WLEN_W'(3);
      wptr_q      <= '0;
      seen_q      <= '0;
      pend_q      <= '0;
      burst_q     <= '0;
      last_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) coef_q[i] <= '0;
    end else begin
      if (cfg_we_i) wlen_q <= cfg_wdata_i;
      if (cmd_i.load_coef && (coef_index_i < CIDX_W'(MAX_WINDOW)))
        coef_q[coef_index_i] <= coef_value_i;
      if (cmd_i.push) begin
        wptr_q  <= wptr_q + PTR_W'(1);
        if (seen_q != '1) seen_q <= seen_q + SEEN_W'(1);
        pend_q  <= pend_q + PEND_W'(1);
        burst_q <= '0;
        last_q  <= last_sample_i;
      end
      if (cmd_i.clear_seq) begin
        seen_q <= '0;
        pend_q <= '0;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        pend_q      <= pend_q - PEND_W'(1);
        burst_q     <= burst_q + PEND_W'(1);
      end
    end
  end

  // sample history write
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) hist_q[wptr_q] <= sample_i;
  end

  // mac pipeline: read, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      span_q <= SPAN_W'(left) + SPAN_W'(right) + SPAN_W'(1);
      dist_q <= PTR_W'(back) + PTR_W'(left);
      k_q    <= '0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.issue) begin
        rd_s_q <= hist_q[rd_idx];
        rd_c_q <= coef_q[k_q];
        k_q    <= k_q + SPAN_W'(1);
        dist_q <= dist_q - PTR_W'(1);
      end
      prod_q <= rd_s_q * rd_c_q;
      if (v2_q) acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // restoring divider by span, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q  <= acc_q[ACC_W-1];
      dq_q   <= acc_mag[ACC_W-1:COEF_FRAC];
      rem_q  <= '0;
      dcnt_q <= DCNT_W'(DVD_W);
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? SPAN_W'(trial - {1'b0, span_q}) : trial[SPAN_W-1:0];
      dq_q   <= {dq_q[DVD_W-2:0], ge};
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  // output word with saturation
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      end_of_sequence_o <= last_q && (pend_q == PEND_W'(1));
      if (!neg_q) begin
        saturated_o <= (dq_q > POS_MAX);
        smoothed_o  <= (dq_q > POS_MAX) ? POS_MAX[SAMPLE_BITS-1:0] : dq_q[SAMPLE_BITS-1:0];
      end else begin
        saturated_o <= (dq_q > NEG_MAX);
        smoothed_o  <= (dq_q > NEG_MAX) ? NEG_MAX[SAMPLE_BITS-1:0]
                                        : SAMPLE_BITS'(-dq_q[SAMPLE_BITS-1:0]);
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/ecws_ctrl.sv
// controller state machine sequencing words through the datapath
module ecws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 operation_i,
  output logic                 in_stall_o,
  input  ecws_pkg::dp_status_t sts_i,
  output ecws_pkg::ctl_cmd_t   cmd_o
);
  import ecws_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == OP_PUSH) begin
            cmd_o.push = 1'b1;
            state_d    = ST_CHECK;
          end else begin
            cmd_o.load_coef = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.emit_ok) begin
          state_d = ST_SETUP;
        end else begin
          cmd_o.clear_seq = sts_i.last;
          state_d         = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        if (sts_i.k_done) state_d = ST_DRAIN;
        else              cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
        if (!sts_i.mac_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_EMIT;
        else                cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/edge_clipped_window_smoother_core.sv
// Sequence: a sample word is pushed, then each result runs setup, the tap issues over
// the span, a mac drain, a restoring divider and an emit back to the check state.
// Input: coefficient words 1 per cycle while idle; a sample word stalls the input until
// its results are issued. The one shared multiplier and the bit-serial divider set the pace.
// Reset: asynchronous active low; coefficients clear to zero, window length 3,
// sequence counters clear; sample history is not cleared.
module edge_clipped_window_smoother_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [ecws_pkg::WLEN_W-1:0]             cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    operation_i,
  input  logic [ecws_pkg::CIDX_W-1:0]             coef_index_i,
  input  logic signed [ecws_pkg::COEF_BITS-1:0]   coef_value_i,
  input  logic signed [ecws_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                    last_sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [ecws_pkg::SAMPLE_BITS-1:0] smoothed_o,
  output logic                                    saturated_o,
  output logic                                    end_of_sequence_o
);
  import ecws_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  // sequencing
  ecws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  ecws_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .sample_i          (sample_i),
    .last_sample_i     (last_sample_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .smoothed_o        (smoothed_o),
    .saturated_o       (saturated_o),
    .end_of_sequence_o (end_of_sequence_o)
  );

`ifndef NO_ASSERTIONS
  // a result is only loaded into an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> !sts.out_full)
    else $error("result loaded over a waiting word");
  // no tap issued past the span
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.issue |-> !sts.k_done)
    else $error("tap issued beyond span");
  // division starts only on a settled accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.div_start |-> !sts.mac_busy)
    else $error("divider started with mac in flight");
  // a sample word blocks the input while it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.push |=> in_stall_o)
    else $error("input open during sample processing");
`endif

endmodule

### test/edge_clipped_window_smoother_core_tb.sv
// testbench for the edge-clipped window smoother core
`timescale 1ns / 1ps

class smooth_scoreboard;
  int unsigned wlen;
  logic signed [15:0] coef_tab [31];
  logic signed [15:0] history [32];
  int unsigned seen;
  int unsigned wr_ptr;
  int unsigned pending;
  logic signed [15:0] exp_avg [$];
  bit exp_sat [$];
  bit exp_eos [$];
  int unsigned mismatches;
  int unsigned checked;

  function new();
    wlen = 3;
    foreach (coef_tab[k]) coef_tab[k] = '0;
    foreach (history[k]) history[k] = '0;
    seen = 0;
    wr_ptr = 0;
    pending = 0;
    mismatches = 0;
    checked = 0;
  endfunction

  function int unsigned half_span();
    int unsigned h;
    h = (wlen >= 1) ? (wlen - 1) / 2 : 0;
    return (h > 15) ? 15 : h;
  endfunction

  // compute the average at the oldest pending position
  function void predict_one(bit fin);
    int unsigned h, back, prior, left, right, span, newest, offs, idx;
    longint acc, q;
    bit sat;
    h = half_span();
    back = pending - 1;
    prior = seen - pending;
    left = (prior < h) ? prior : h;
    right = (back < h) ? back : h;
    span = left + right + 1;
    newest = (wr_ptr - 1) & 31;
    acc = 0;
    for (int unsigned k = 0; k < span; k++) begin
      offs = back + left - k;
      idx = (newest - offs) & 31;
      if (k < 31) acc += longint'(history[idx]) * longint'(coef_tab[k]);
    end
    q = acc / (longint'(span) <<< 14);
    sat = 0;
    if (q > 32767) begin
      q = 32767;
      sat = 1;
    end
    if (q < -32768) begin
      q = -32768;
      sat = 1;
    end
    exp_avg.push_back(q[15:0]);
    exp_sat.push_back(sat);
    exp_eos.push_back(fin);
    pending--;
  endfunction

  // note one accepted input word
  function void note_word(bit op, logic [4:0] cidx, logic signed [15:0] cval,
                          logic signed [15:0] smp, bit lst);
    int n;
    if (op == ecws_pkg::OP_LOAD_COEF) begin
      if (cidx < 31) coef_tab[cidx] = cval;
      return;
    end
    history[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1) & 31;
    if (seen < 63) seen++;
    pending++;
    if (lst) begin
      while (pending > 0) predict_one(pending == 1);
      seen = 0;
      return;
    end
    n = 0;
    while (pending > half_span() && n < 16) begin
      predict_one(0);
      n++;
    end
  endfunction

  // compare one accepted result word with the oldest expectation
  function void check_word(logic signed [15:0] avg, bit sat, bit eos);
    checked++;
    if (exp_avg.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word avg=%0d", avg);
      return;
    end
    if (avg !== exp_avg[0] || sat !== exp_sat[0] || eos !== exp_eos[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp avg=%0d sat=%0b eos=%0b got avg=%0d sat=%0b eos=%0b",
                 exp_avg[0], exp_sat[0], exp_eos[0], avg, sat, eos);
    end
    void'(exp_avg.pop_front());
    void'(exp_sat.pop_front());
    void'(exp_eos.pop_front());
  endfunction
endclass

module edge_clipped_window_smoother_core_tb;
  import ecws_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [WLEN_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic operation_i = 0;
  logic [CIDX_W-1:0] coef_index_i = '0;
  logic signed [COEF_BITS-1:0] coef_value_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic last_sample_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [SAMPLE_BITS-1:0] smoothed_o;
  logic saturated_o;
  logic end_of_sequence_o;

  smooth_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned seqs_sent = 0;

  edge_clipped_window_smoother_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .operation_i(operation_i), .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i), .sample_i(sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .smoothed_o(smoothed_o), .saturated_o(saturated_o),
    .end_of_sequence_o(end_of_sequence_o)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // receiver: random stall, check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word(smoothed_o, saturated_o, end_of_sequence_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // send one word, holding it until accepted; valid drops only while idling
  task automatic send_word(bit op, logic [4:0] cidx, logic [15:0] cval,
                           logic [15:0] smp, bit lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= op;
    coef_index_i <= cidx;
    coef_value_i <= cval;
    sample_i <= smp;
    last_sample_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(op, cidx, cval, smp, lst);
    words_sent++;
  endtask

  task automatic push(logic [15:0] smp, bit lst);
    send_word(OP_PUSH, 5'($urandom), 16'($urandom), smp, lst);
    if (lst) seqs_sent++;
  endtask

  task automatic load(logic [4:0] cidx, logic [15:0] cval);
    send_word(OP_LOAD_COEF, cidx, cval, 16'($urandom), 1'($urandom));
  endtask

  // wait for the pipe to empty, then let the core settle
  task automatic drain();
    in_valid_i <= 0;
    while (board.exp_avg.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_window(logic [4:0] len);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.wlen = len;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_sequence(int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) load(5'($urandom_range(31)), 16'($urandom));
      push(rand_sample(), k == len - 1);
    end
  endtask

  initial begin
    int unsigned lens [6];
    lens = '{3, 31, 4, 0, 1, 9};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: short sequences with reset coefficients, then extreme taps
    push(16'h7fff, 1);
    push(16'h8000, 0);
    push(16'h7fff, 1);
    for (int k = 0; k < 3; k++) load(5'(k), 16'h7fff);
    load(5'd31, 16'h1234);
    push(16'h7fff, 0);
    push(16'h7fff, 0);
    push(16'h7fff, 0);
    push(16'h7fff, 1);
    load(5'd0, 16'h8000);
    load(5'd1, 16'h8000);
    load(5'd2, 16'h8000);
    push(16'h8000, 0);
    push(16'h8000, 0);
    push(16'h0001, 1);
    set_window(5'd31);
    for (int k = 0; k < 31; k++) load(5'(k), 16'($urandom));
    random_sequence(4);

    // random phases across window settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      set_window(ph < 6 ? 5'(lens[ph]) : 5'($urandom));
      for (int s = 0; s < 4; s++)
        random_sequence(($urandom_range(9) == 0) ? 70 : $urandom_range(1, 8));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    $display("covered %0d input words in %0d sequences, %0d results checked",
             words_sent, seqs_sent, board.checked);
    $display("window lengths 0..31 incl. even, long runs, saturating taps");
    if (board.mismatches == 0 && board.exp_avg.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
